// File: hdl/s1bsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package s1bsh_pkg;

   // request kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // digest and block geometry
   localparam logic [4:0] DIGEST_LEN = 5'd20;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [6:0] LAST_ROUND = 7'd79;

   // initial vector
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hEFCDAB89;
   localparam logic [31:0] IV_C = 32'h98BADCFE;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [31:0] IV_E = 32'hC3D2E1F0;

   // round constants, one per twenty rounds
   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] digest_byte;
      logic [4:0] byte_position;
      logic       last_byte;
   } rsp_type;

   // working variables of the compression
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } abcde_type;

endpackage
`default_nettype wire

// File: hdl/s1bsh_round.sv
`timescale 1ns / 1ps
`default_nettype none
module s1bsh_round (
   input  s1bsh_pkg::abcde_type cur,
   input  logic [6:0]           rnd,
   input  logic [31:0]          w0,
   input  logic [31:0]          w2,
   input  logic [31:0]          w8,
   input  logic [31:0]          w13,
   output s1bsh_pkg::abcde_type nxt,
   output logic [31:0]          w_new
);

   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;
   logic [31:0] mix;

   // pick round function and constant by phase
   always_comb begin
      if (rnd < 7'd20) begin
         f_val = (cur.b & cur.c) | (~cur.b & cur.d);
         k_val = s1bsh_pkg::K_0;
      end else if (rnd < 7'd40) begin
         f_val = cur.b ^ cur.c ^ cur.d;
         k_val = s1bsh_pkg::K_1;
      end else if (rnd < 7'd60) begin
         f_val = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
         k_val = s1bsh_pkg::K_2;
      end else begin
         f_val = cur.b ^ cur.c ^ cur.d;
         k_val = s1bsh_pkg::K_3;
      end
   end

   // one SHA-1 round
   assign t_val = {cur.a[26:0], cur.a[31:27]} + f_val + cur.e + w0 + k_val;

   always_comb begin
      nxt.a = t_val;
      nxt.b = cur.a;
      nxt.c = {cur.b[1:0], cur.b[31:2]};
      nxt.d = cur.c;
      nxt.e = cur.d;
   end

   // extend the message schedule by one word
   assign mix   = w13 ^ w8 ^ w2 ^ w0;
   assign w_new = {mix[30:0], mix[31]};

endmodule
`default_nettype wire

// File: hdl/sha1_byte_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Handshake          | Payload
// req     | in  | req_valid/req_stall | s1bsh_pkg::req_type (kind, data_byte)
// rsp     | out | rsp_valid/rsp_stall | s1bsh_pkg::rsp_type (digest_byte, position, last)
// csr     | in  | csr_wr_en           | csr_wr_data: digest byte count
//
// A data request writes its byte into the block; the 64th byte of a block starts
// a compression (80 rounds through one shared round unit, then the chaining add).
// A finish request writes padding one byte per cycle up to the block end,
// runs one or two compressions, then emits one digest byte per cycle while rsp_stall allows.
// Reset is synchronous and restores the initial vector and a count of 20.
// req_stall is high while a block is compressed, padded or emitted;
// rsp_stall holds the output register and pauses emission, but does not block requests once idle.
module sha1_byte_stream_hasher_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  s1bsh_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output s1bsh_pkg::rsp_type   rsp_data,
   input  logic                 csr_wr_en,
   input  logic [4:0]           csr_wr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FINAL = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [4:0]  pos_ff, pos_in;
   logic [4:0]  dlen_ff;
   logic        mark_ff, mark_in;
   logic        extra_ff, extra_in;
   logic        lastblk_ff, lastblk_in;
   logic        fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   s1bsh_pkg::rsp_type   rsp_data_ff;
   s1bsh_pkg::abcde_type abcde_ff;
   s1bsh_pkg::abcde_type abcde_nxt;
   logic [31:0] chain_ff [5];
   logic [31:0] win_ff [16];
   logic [31:0] w_new;

   logic        wr_en;
   logic [7:0]  wr_val;
   logic        start_cmp;
   logic        chain_add;
   logic        chain_clr;
   logic        rsp_load;
   logic [4:0]  n_bytes;
   logic [7:0]  len_byte;
   logic [31:0] chain_word;

   // saturate digest length
   assign n_bytes = (dlen_ff > s1bsh_pkg::DIGEST_LEN) ? s1bsh_pkg::DIGEST_LEN : dlen_ff;

   // big-endian length byte for positions 56..63
   assign len_byte = bitlen_ff[{~fill_ff[2:0], 3'b000} +: 8];

   // digest byte source word
   assign chain_word = chain_ff[pos_ff[4:2]];

   s1bsh_round u_round (
      .cur   (abcde_ff),
      .rnd   (rnd_ff),
      .w0    (win_ff[0]),
      .w2    (win_ff[2]),
      .w8    (win_ff[8]),
      .w13   (win_ff[13]),
      .nxt   (abcde_nxt),
      .w_new (w_new)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bitlen_in    = bitlen_ff;
      rnd_in       = rnd_ff;
      pos_in       = pos_ff;
      mark_in      = mark_ff;
      extra_in     = extra_ff;
      lastblk_in   = lastblk_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_val       = 8'h00;
      start_cmp    = 1'b0;
      chain_add    = 1'b0;
      chain_clr    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.kind == s1bsh_pkg::KIND_DATA) begin
                  wr_en     = 1'b1;
                  wr_val    = req_data.data_byte;
                  fill_in   = fill_ff + 6'd1;
                  bitlen_in = bitlen_ff + 64'd8;
                  if (fill_ff == s1bsh_pkg::LAST_POS) begin
                     start_cmp = 1'b1;
                  end
               end else begin
                  state_in = ST_PAD;
                  mark_in  = 1'b1;
                  extra_in = 1'b0;
                  fin_in   = 1'b1;
               end
            end
         end
         ST_PAD: begin
            wr_en   = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (mark_ff) begin
               wr_val   = s1bsh_pkg::PAD_BYTE;
               mark_in  = 1'b0;
               extra_in = (fill_ff >= s1bsh_pkg::LEN_POS) && (fill_ff != s1bsh_pkg::LAST_POS);
               if (fill_ff == s1bsh_pkg::LAST_POS) begin
                  start_cmp = 1'b1;
               end
            end else if (extra_ff) begin
               wr_val = 8'h00;
               if (fill_ff == s1bsh_pkg::LAST_POS) begin
                  start_cmp = 1'b1;
                  extra_in  = 1'b0;
               end
            end else begin
               wr_val = (fill_ff >= s1bsh_pkg::LEN_POS) ? len_byte : 8'h00;
               if (fill_ff == s1bsh_pkg::LAST_POS) begin
                  start_cmp  = 1'b1;
                  lastblk_in = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == s1bsh_pkg::LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (lastblk_ff) begin
               lastblk_in = 1'b0;
               if (n_bytes == 5'd0) begin
                  chain_clr = 1'b1;
                  bitlen_in = 64'd0;
                  fin_in    = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  chain_add = 1'b1;
                  pos_in    = 5'd0;
                  state_in  = ST_OUT;
               end
            end else begin
               chain_add = 1'b1;
               state_in  = fin_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               pos_in       = pos_ff + 5'd1;
               if (pos_ff == n_bytes - 5'd1) begin
                  chain_clr = 1'b1;
                  bitlen_in = 64'd0;
                  fin_in    = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // enter compression
      if (start_cmp) begin
         state_in = ST_ROUND;
         rnd_in   = 7'd0;
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= 6'd0;
         bitlen_ff    <= 64'd0;
         rnd_ff       <= 7'd0;
         pos_ff       <= 5'd0;
         mark_ff      <= 1'b0;
         extra_ff     <= 1'b0;
         lastblk_ff   <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dlen_ff      <= s1bsh_pkg::DIGEST_LEN;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bitlen_ff    <= bitlen_in;
         rnd_ff       <= rnd_in;
         pos_ff       <= pos_in;
         mark_ff      <= mark_in;
         extra_ff     <= extra_in;
         lastblk_ff   <= lastblk_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            dlen_ff <= csr_wr_data;
         end
      end
   end

   // write bytes into the block, or slide the schedule window
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= w_new;
      end else if (wr_en) begin
         win_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wr_val;
      end
   end

   // load or advance working variables
   always_ff @(posedge clock) begin
      if (start_cmp) begin
         abcde_ff.a <= chain_ff[0];
         abcde_ff.b <= chain_ff[1];
         abcde_ff.c <= chain_ff[2];
         abcde_ff.d <= chain_ff[3];
         abcde_ff.e <= chain_ff[4];
      end else if (state_ff == ST_ROUND) begin
         abcde_ff <= abcde_nxt;
      end
   end

   // chaining words: add block result, or return to the initial vector
   always_ff @(posedge clock) begin
      if (reset || chain_clr) begin
         chain_ff[0] <= s1bsh_pkg::IV_A;
         chain_ff[1] <= s1bsh_pkg::IV_B;
         chain_ff[2] <= s1bsh_pkg::IV_C;
         chain_ff[3] <= s1bsh_pkg::IV_D;
         chain_ff[4] <= s1bsh_pkg::IV_E;
      end else if (chain_add) begin
         chain_ff[0] <= chain_ff[0] + abcde_ff.a;
         chain_ff[1] <= chain_ff[1] + abcde_ff.b;
         chain_ff[2] <= chain_ff[2] + abcde_ff.c;
         chain_ff[3] <= chain_ff[3] + abcde_ff.d;
         chain_ff[4] <= chain_ff[4] + abcde_ff.e;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.digest_byte   <= chain_word[{~pos_ff[1:0], 3'b000} +: 8];
         rsp_data_ff.byte_position <= pos_ff;
         rsp_data_ff.last_byte     <= (pos_ff == n_bytes - 5'd1);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
